@@ sv/tdtf_pkg.sv @@
// types and constants shared by the depth-tested fragment core
`default_nettype none
package tdtf_pkg;
   localparam int DefaultWidth  = 800;
   localparam int DefaultHeight = 800;
   localparam logic signed [15:0] DepthFloor = 16'sh8000;

   typedef struct packed {
      logic [9:0]         vertex_a_x;
      logic [9:0]         vertex_a_y;
      logic signed [15:0] vertex_a_z;
      logic [9:0]         vertex_b_x;
      logic [9:0]         vertex_b_y;
      logic signed [15:0] vertex_b_z;
      logic [9:0]         vertex_c_x;
      logic [9:0]         vertex_c_y;
      logic signed [15:0] vertex_c_z;
      logic [9:0]         pixel_x;
      logic [9:0]         pixel_y;
      logic [8:0]         intensity;
   } req_type;

   typedef struct packed {
      logic               drawn;
      logic [9:0]         out_x;
      logic [9:0]         out_y;
      logic [7:0]         shade;
      logic signed [15:0] new_depth;
   } rsp_type;
endpackage
`default_nettype wire

@@ sv/tdtf_div.sv @@
// restoring divider: floor quotient of a 40-bit signed numerator by a positive 21-bit divisor, low 16 bits out
`default_nettype none
module tdtf_div import tdtf_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               go,
   input  wire logic signed [39:0] num,
   input  wire logic [20:0]        den,
   output logic                    done,
   output logic signed [15:0]      quo
);
   logic [39:0] mag_ff, mag_in;
   logic [39:0] q_ff, q_in;
   logic [21:0] rem_ff, rem_in;
   logic [20:0] den_ff;
   logic        neg_ff;
   logic [5:0]  cnt_ff;
   logic        run_ff;
   logic [21:0] trial;
   logic [40:0] qs;

   always_comb begin
      trial  = {rem_ff[20:0], mag_ff[39]};
      mag_in = {mag_ff[38:0], 1'b0};
      if (trial >= {1'b0, den_ff}) begin
         rem_in = trial - {1'b0, den_ff};
         q_in   = {q_ff[38:0], 1'b1};
      end else begin
         rem_in = trial;
         q_in   = {q_ff[38:0], 1'b0};
      end
      // floor for negative numerator: -(q) minus one if remainder nonzero
      if (neg_ff) qs = -{1'b0, q_ff} - ((rem_ff != '0) ? 41'd1 : 41'd0);
      else        qs = {1'b0, q_ff};
      quo = qs[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done   <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done <= 1'b0;
         if (go) begin
            run_ff <= 1'b1;
            cnt_ff <= 6'd40;
            neg_ff <= num[39];
            mag_ff <= num[39] ? 40'(-num) : 40'(num);
            den_ff <= den;
            rem_ff <= '0;
            q_ff   <= '0;
         end else if (run_ff) begin
            mag_ff <= mag_in;
            rem_ff <= rem_in;
            q_ff   <= q_in;
            cnt_ff <= cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               run_ff <= 1'b0;
               done   <= 1'b1;
            end
         end
      end
   end
endmodule
`default_nettype wire

@@ sv/triangle_depth_test_fragment_core.sv @@
// top level: barycentric fragment test with z-buffer memory
// Usage: pulse start with req_item while busy is low; the item is taken at that
// edge and busy rises. The core computes the edge weights and doubled area in
// registered steps, divides the weighted depth sum by the area in a 40-step
// serial divider, then reads the z-buffer (synchronous, registered read),
// compares, and writes back on a strictly greater depth. One rsp_item per
// item appears for exactly one cycle with rsp_valid high; the receiver cannot
// stall. An item that passes the triangle and buffer tests keeps busy high
// through four setup steps, one divider load, 40 divide steps, the memory
// read, a wait and the compare/write. The result is on the ports in the next
// cycle, and the next start is taken in that same cycle.
// Rejected items (zero area, outside the triangle or the buffer) skip the
// divider and the memory; a done state registers their undrawn result.
// After reset a clearing pass writes the floor depth to every entry, one per
// cycle (WIDTH*HEIGHT entries, 640000 at defaults); busy stays high meanwhile.
// Only one item is in flight, so read and write to the same entry never overlap.
`default_nettype none
module triangle_depth_test_fragment_core import tdtf_pkg::*; #(
   parameter int WIDTH  = DefaultWidth,
   parameter int HEIGHT = DefaultHeight
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   output logic      busy,
   input  wire req_type req_item,
   output logic      rsp_valid,
   output rsp_type   rsp_item
);
   localparam int Depth = WIDTH * HEIGHT;
   localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_DIFF, S_MUL, S_WGT, S_PROD, S_SUM, S_DIV, S_READ, S_TEST, S_DONE
   } state_type;

   state_type state_ff;
   req_type   req_ff;
   logic signed [15:0] mem [Depth];
   logic signed [15:0] rd_ff;
   logic [AddrW-1:0]   clr_ff, addr_ff;
   logic signed [10:0] dxba_ff, dyba_ff, dxca_ff, dyca_ff, dxap_ff, dyap_ff;
   logic signed [21:0] m0_ff, m1_ff, m2_ff, m3_ff, m4_ff, m5_ff;
   logic signed [22:0] wb_ff, wc_ff, d_ff, wa_ff;
   logic signed [39:0] pa_ff, pb_ff, pc_ff;
   logic signed [15:0] z_ff;
   logic        div_go, div_done, inbuf;
   logic signed [15:0] div_q;
   logic [16:0] shade_w;
   logic signed [22:0] wb_n, wc_n, d_n, wa_n;

   tdtf_div u_div (.clock, .reset, .go(div_go), .num(pa_ff + pb_ff + pc_ff),
                   .den(d_ff[20:0]), .done(div_done), .quo(div_q));

   assign busy   = (state_ff != S_IDLE);
   assign div_go = (state_ff == S_SUM);
   assign inbuf  = ({22'd0, req_ff.pixel_x} < 32'(WIDTH)) &&
                   ({22'd0, req_ff.pixel_y} < 32'(HEIGHT));
   assign shade_w = 17'(req_ff.intensity) * 17'd255;

   always_comb begin
      wc_n = 23'(m0_ff) - 23'(m1_ff);
      wb_n = 23'(m2_ff) - 23'(m3_ff);
      d_n  = 23'(m4_ff) - 23'(m5_ff);
      if (d_n < 0) begin
         d_n = -d_n; wb_n = -wb_n; wc_n = -wc_n;
      end
      wa_n = d_n - wb_n - wc_n;
   end

   always_ff @(posedge clock) begin
      rsp_valid <= 1'b0;
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
      end else begin
         case (state_ff)
            S_CLEAR: begin
               mem[clr_ff] <= DepthFloor;
               clr_ff <= clr_ff + 1'b1;
               if (32'(clr_ff) == 32'(Depth - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: if (start) begin
               req_ff   <= req_item;
               state_ff <= S_DIFF;
            end
            S_DIFF: begin
               dxba_ff <= 11'(req_ff.vertex_b_x) - 11'(req_ff.vertex_a_x);
               dyba_ff <= 11'(req_ff.vertex_b_y) - 11'(req_ff.vertex_a_y);
               dxca_ff <= 11'(req_ff.vertex_c_x) - 11'(req_ff.vertex_a_x);
               dyca_ff <= 11'(req_ff.vertex_c_y) - 11'(req_ff.vertex_a_y);
               dxap_ff <= 11'(req_ff.vertex_a_x) - 11'(req_ff.pixel_x);
               dyap_ff <= 11'(req_ff.vertex_a_y) - 11'(req_ff.pixel_y);
               addr_ff <= AddrW'(32'(req_ff.pixel_x) + 32'(req_ff.pixel_y) * 32'(WIDTH));
               state_ff <= S_MUL;
            end
            S_MUL: begin
               m0_ff <= dxba_ff * dyap_ff;
               m1_ff <= dxap_ff * dyba_ff;
               m2_ff <= dxap_ff * dyca_ff;
               m3_ff <= dxca_ff * dyap_ff;
               m4_ff <= dxca_ff * dyba_ff;
               m5_ff <= dxba_ff * dyca_ff;
               state_ff <= S_WGT;
            end
            S_WGT: begin
               wa_ff <= wa_n; wb_ff <= wb_n; wc_ff <= wc_n; d_ff <= d_n;
               if (d_n == 0 || wa_n < 0 || wb_n < 0 || wc_n < 0 || !inbuf)
                  state_ff <= S_DONE;
               else state_ff <= S_PROD;
            end
            S_PROD: begin
               pa_ff <= 40'(wa_ff) * 40'(req_ff.vertex_a_z);
               pb_ff <= 40'(wb_ff) * 40'(req_ff.vertex_b_z);
               pc_ff <= 40'(wc_ff) * 40'(req_ff.vertex_c_z);
               state_ff <= S_SUM;
            end
            S_SUM: begin
               state_ff <= S_DIV;
            end
            S_DIV: if (div_done) begin
               z_ff  <= div_q;
               rd_ff <= mem[addr_ff];
               state_ff <= S_READ;
            end
            S_READ: state_ff <= S_TEST;
            S_TEST: begin
               rsp_valid <= 1'b1;
               rsp_item.out_x <= req_ff.pixel_x;
               rsp_item.out_y <= req_ff.pixel_y;
               if (rd_ff < z_ff) begin
                  mem[addr_ff] <= z_ff;
                  rsp_item.drawn     <= 1'b1;
                  rsp_item.shade     <= shade_w[16] ? 8'hff : shade_w[15:8];
                  rsp_item.new_depth <= z_ff;
               end else begin
                  rsp_item.drawn     <= 1'b0;
                  rsp_item.shade     <= '0;
                  rsp_item.new_depth <= '0;
               end
               state_ff <= S_IDLE;
            end
            S_DONE: begin
               rsp_valid <= 1'b1;
               rsp_item.out_x     <= req_ff.pixel_x;
               rsp_item.out_y     <= req_ff.pixel_y;
               rsp_item.drawn     <= 1'b0;
               rsp_item.shade     <= '0;
               rsp_item.new_depth <= '0;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

@@ sv/tdtf_checker.sv @@
// port-level checks for the fragment core, bound to the top level
`default_nettype none
module tdtf_checker import tdtf_pkg::*; (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    start,
   input wire logic    busy,
   input wire logic    rsp_valid,
   input wire rsp_type rsp_item
);
   a_take_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("busy did not rise");
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$past(busy) == 1'b0) else $error("result while idle");
   a_zero_shade: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.drawn |-> rsp_item.shade == 8'd0 && rsp_item.new_depth == 16'sd0)
      else $error("undrawn result carries data");
   a_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("two results in a row");
endmodule

bind triangle_depth_test_fragment_core tdtf_checker u_tdtf_checker (
   .clock, .reset, .start, .busy, .rsp_valid, .rsp_item);
`default_nettype wire

@@ bench/tb_triangle_depth_test_fragment_core.sv @@
// testbench for the depth-tested triangle fragment core: directed and random items
`timescale 1ns / 1ps
module tb_triangle_depth_test_fragment_core;
   import tdtf_pkg::*;

   localparam int FbWidth  = DefaultWidth;
   localparam int FbHeight = DefaultHeight;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_item = '0;
   logic rsp_valid;
   rsp_type rsp_item;

   logic signed [15:0] zbuf [FbWidth*FbHeight];
   rsp_type fragment_queue [$];
   int error_count = 0;
   bit idle_bursts = 1'b1;

   triangle_depth_test_fragment_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #400ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic rsp_type shade_fragment(req_type r);
      longint ax, ay, az, bx, by, bz, cx, cy, cz, px, py;
      longint wa, wb, wc, area, num, q;
      int idx;
      rsp_type o;
      ax = r.vertex_a_x; ay = r.vertex_a_y; az = r.vertex_a_z;
      bx = r.vertex_b_x; by = r.vertex_b_y; bz = r.vertex_b_z;
      cx = r.vertex_c_x; cy = r.vertex_c_y; cz = r.vertex_c_z;
      px = r.pixel_x; py = r.pixel_y;
      o = '0;
      o.out_x = r.pixel_x;
      o.out_y = r.pixel_y;
      wc = (bx - ax) * (ay - py) - (ax - px) * (by - ay);
      wb = (ax - px) * (cy - ay) - (cx - ax) * (ay - py);
      area = (cx - ax) * (by - ay) - (bx - ax) * (cy - ay);
      if (area == 0) return o;
      if (area < 0) begin
         area = -area; wb = -wb; wc = -wc;
      end
      wa = area - wb - wc;
      if (wa < 0 || wb < 0 || wc < 0 || px >= FbWidth || py >= FbHeight) return o;
      num = wa * az + wb * bz + wc * cz;
      q = num / area;
      if (num % area != 0 && num < 0) q = q - 1;
      idx = int'(px + py * FbWidth);
      if (longint'(zbuf[idx]) < q) begin
         zbuf[idx] = q[15:0];
         o.drawn = 1'b1;
         o.new_depth = q[15:0];
         q = (255 * longint'(r.intensity)) >>> 8;
         o.shade = (q > 255) ? 8'd255 : q[7:0];
      end
      return o;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (fragment_queue.size() == 0) begin
            $display("%0t: unexpected fragment %p", $time, rsp_item);
            error_count++;
         end else begin
            want = fragment_queue.pop_front();
            if (rsp_item.drawn !== want.drawn)
               $display("%0t: drawn exp %0d got %0d", $time, want.drawn, rsp_item.drawn);
            if (rsp_item.out_x !== want.out_x)
               $display("%0t: out_x exp %0d got %0d", $time, want.out_x, rsp_item.out_x);
            if (rsp_item.out_y !== want.out_y)
               $display("%0t: out_y exp %0d got %0d", $time, want.out_y, rsp_item.out_y);
            if (rsp_item.shade !== want.shade)
               $display("%0t: shade exp %0d got %0d", $time, want.shade, rsp_item.shade);
            if (rsp_item.new_depth !== want.new_depth)
               $display("%0t: new_depth exp %0d got %0d", $time, want.new_depth,
                  rsp_item.new_depth);
            if (rsp_item !== want) error_count++;
         end
      end
   end

   task automatic send_fragment(req_type r);
      int gap;
      if (idle_bursts && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 19);
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_item <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      fragment_queue.push_back(shade_fragment(r));
      start <= 1'b0;
      @(posedge clock);
   endtask

   function automatic req_type make_fragment(int ax, int ay, int bx, int by, int cx, int cy,
                                             int az, int bz, int cz, int px, int py, int inten);
      req_type r;
      r.vertex_a_x = 10'(ax); r.vertex_a_y = 10'(ay); r.vertex_a_z = 16'(az);
      r.vertex_b_x = 10'(bx); r.vertex_b_y = 10'(by); r.vertex_b_z = 16'(bz);
      r.vertex_c_x = 10'(cx); r.vertex_c_y = 10'(cy); r.vertex_c_z = 16'(cz);
      r.pixel_x = 10'(px); r.pixel_y = 10'(py); r.intensity = 9'(inten);
      return r;
   endfunction

   task automatic test_directed();
      send_fragment(make_fragment(0, 0, 10, 0, 0, 10, 100, 200, 300, 2, 2, 256));
      send_fragment(make_fragment(0, 0, 10, 0, 0, 10, 100, 200, 300, 2, 2, 256));
      send_fragment(make_fragment(0, 0, 10, 0, 0, 10, 900, 900, 900, 2, 2, 511));
      send_fragment(make_fragment(0, 0, 10, 0, 0, 10, 900, 900, 900, 2, 2, 128));
      send_fragment(make_fragment(0, 0, 5, 5, 9, 9, 1, 2, 3, 3, 3, 200));
      send_fragment(make_fragment(0, 0, 10, 0, 0, 10, 50, 50, 50, 5, 0, 100));
      send_fragment(make_fragment(0, 0, 10, 0, 0, 10, 50, 50, 50, 8, 8, 100));
      send_fragment(make_fragment(0, 0, 10, 0, 0, 10, 50, 50, 50, 0, 0, 0));
      send_fragment(make_fragment(0, 10, 10, 0, 0, 0, -16384, -16384, -16384, 1, 1, 1));
      send_fragment(make_fragment(0, 0, 1023, 0, 0, 1023, 16384, -16384, 0, 799, 223, 256));
      send_fragment(make_fragment(0, 0, 1023, 0, 0, 1023, 1, 1, 1, 800, 10, 256));
      send_fragment(make_fragment(0, 0, 1023, 0, 0, 1023, 1, 1, 1, 10, 800, 256));
      send_fragment(make_fragment(1023, 1023, 0, 1023, 1023, 0, 32767, 32767, 32767,
                                  1023, 1023, 256));
      send_fragment(make_fragment(1023, 1023, 0, 1023, 1023, 0, -32768, 32767, -1,
                                  799, 799, 511));
      send_fragment(make_fragment(0, 0, 7, 0, 0, 3, -7, 11, -13, 1, 1, 77));
      send_fragment(make_fragment(0, 0, 7, 0, 0, 3, -32768, -32768, -32768, 2, 1, 77));
   endtask

   task automatic test_random(int count);
      req_type r;
      int ox, oy, span;
      repeat (count) begin
         if ($urandom_range(0, 9) == 0) begin
            r = req_type'({$urandom, $urandom, $urandom, $urandom, $urandom});
         end else begin
            span = ($urandom_range(0, 15) == 0) ? 1023 : $urandom_range(1, 40);
            ox = $urandom_range(0, 1023 - span);
            oy = $urandom_range(0, 1023 - span);
            r = make_fragment(ox + $urandom_range(0, span), oy + $urandom_range(0, span),
                              ox + $urandom_range(0, span), oy + $urandom_range(0, span),
                              ox + $urandom_range(0, span), oy + $urandom_range(0, span),
                              $urandom_range(0, 32768) - 16384,
                              $urandom_range(0, 32768) - 16384,
                              $urandom_range(0, 65535),
                              ox + $urandom_range(0, span), oy + $urandom_range(0, span),
                              $urandom_range(0, 511));
            if ($urandom_range(0, 3) != 0)
               r.vertex_c_z = 16'($urandom_range(0, 32768) - 16384);
            if ($urandom_range(0, 7) == 0) begin
               r.pixel_x = 10'($urandom_range(0, 1023));
               r.pixel_y = 10'($urandom_range(0, 1023));
            end
         end
         send_fragment(r);
      end
   endtask

   initial begin
      foreach (zbuf[i]) zbuf[i] = DepthFloor;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(1600);
      idle_bursts = 1'b0;
      test_random(240);
      while (fragment_queue.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule

@@ triangle_depth_test_fragment_core.f @@
sv/tdtf_pkg.sv
sv/tdtf_div.sv
sv/triangle_depth_test_fragment_core.sv
sv/tdtf_checker.sv
bench/tb_triangle_depth_test_fragment_core.sv
